/* sv/rfm_pkg.sv */
package rfm_pkg;

    localparam int EDGE_W    = 32;
    localparam int RATE_W    = 27;
    localparam int FX100_W   = 34;
    localparam int HUND_W    = 7;
    localparam int PROD_W    = EDGE_W + HUND_W;
    localparam int DATA_OUT_W = 104;

    localparam logic [RATE_W-1:0] RATE_RESET = 27'd1000000;
    localparam logic [HUND_W-1:0] SCALE      = 7'd100;

    localparam logic [0:0] REG_COUNT_RATE = 1'b0;

    typedef struct packed {
        logic full;
        logic empty;
    } rfm_q_status_t;

    typedef struct packed {
        logic push;
        logic [EDGE_W-1:0] period;
    } rfm_q_write_t;

endpackage

/* sv/reciprocal_frequency_meter.sv */
// Reciprocal frequency meter. Each transfer on the s_axis channel carries the
// capture counter value latched at one rising edge of the measured signal.
// Edges pair up as opening and closing edge; a closing edge forms the period and,
// when it is nonzero, one result transfer appears on the m_axis channel with
// the period, the frequency in hundredths of hertz and its split into whole
// hertz and hundredths. A zero period produces no transfer.
// The edge channel accepts one transfer per cycle while the two-entry period
// queue has room. The divider behind the queue takes each period through
// 27 integer quotient steps and 7 hundredths steps, with setup and finish
// states around them, and sets m_axis_tvalid as a register in its finish
// state. The divider takes a new period only once the result register is
// empty, so it finishes one measurement before it starts on the next.
// count_rate_hz is written through the APB port at address 0 and resets to
// 1000000. Reset returns the meter to awaiting a first edge and empties the
// queue and the result register. When the receiver holds m_axis_tready low,
// the result waits in its register, the divider takes no new period,
// and s_axis_tready falls once the queue fills.
module reciprocal_frequency_meter
    import rfm_pkg::*;
#(
    parameter int COUNTER_WIDTH = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [EDGE_W-1:0]       s_axis_tdata,   // edge_time
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // period_ticks, freq_x100, freq_whole_hz, freq_hundredths, zero padding
    output logic [DATA_OUT_W-1:0]   m_axis_tdata,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [RATE_W-1:0]  rate_reg;
    rfm_q_status_t      q_status;
    rfm_q_write_t       q_write;
    logic [EDGE_W-1:0]  head;
    logic               pop;
    logic [EDGE_W-1:0]  period_ticks;
    logic [FX100_W-1:0] freq_x100;
    logic [RATE_W-1:0]  freq_whole_hz;
    logic [HUND_W-1:0]  freq_hundredths;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_COUNT_RATE) ? 32'(rate_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= RATE_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_COUNT_RATE)
        begin
            rate_reg <= pwdata[RATE_W-1:0];
        end
    end

    assign m_axis_tdata = {4'd0, freq_hundredths, freq_whole_hz, freq_x100, period_ticks};

    rfm_front #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .edge_time(s_axis_tdata),
        .q_status (q_status),
        .q_write  (q_write)
    );

    rfm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_write (q_write),
        .pop     (pop),
        .head    (head),
        .q_status(q_status)
    );

    rfm_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .count_rate_hz  (rate_reg),
        .q_status       (q_status),
        .head           (head),
        .pop            (pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .period_ticks   (period_ticks),
        .freq_x100      (freq_x100),
        .freq_whole_hz  (freq_whole_hz),
        .freq_hundredths(freq_hundredths)
    );

endmodule

/* sv/rfm_front.sv */
module rfm_front
    import rfm_pkg::*;
#(
    parameter int COUNTER_WIDTH = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [EDGE_W-1:0]   edge_time,
    input  rfm_q_status_t       q_status,
    output rfm_q_write_t        q_write
);

    localparam int CW = (COUNTER_WIDTH > EDGE_W) ? EDGE_W : COUNTER_WIDTH;

    logic          phase_reg;
    logic          phase_next;
    logic [CW-1:0] first_reg;
    logic [CW-1:0] first_next;
    logic [CW-1:0] diff;
    logic          accept;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign diff     = edge_time[CW-1:0] - first_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        first_next     = first_reg;
        q_write.push   = 1'b0;
        q_write.period = EDGE_W'(diff);
        if (accept)
        begin
            if (!phase_reg)
            begin
                first_next = edge_time[CW-1:0];
                phase_next = 1'b1;
            end
            else
            begin
                phase_next   = 1'b0;
                q_write.push = (diff != '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
    end

endmodule

/* sv/rfm_queue.sv */
module rfm_queue
    import rfm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  rfm_q_write_t        q_write,
    input  logic                pop,
    output logic [EDGE_W-1:0]   head,
    output rfm_q_status_t       q_status
);

    logic [EDGE_W-1:0] entry_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic              do_push;
    logic              do_pop;

    assign q_status.full  = (count_reg == 2'd2);
    assign q_status.empty = (count_reg == 2'd0);
    assign head           = entry_reg[rd_ptr_reg];
    assign do_push        = q_write.push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= q_write.period;
        end
    end

endmodule

/* sv/rfm_back.sv */
module rfm_back
    import rfm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [RATE_W-1:0]   count_rate_hz,
    input  rfm_q_status_t       q_status,
    input  logic [EDGE_W-1:0]   head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [EDGE_W-1:0]   period_ticks,
    output logic [FX100_W-1:0]  freq_x100,
    output logic [RATE_W-1:0]   freq_whole_hz,
    output logic [HUND_W-1:0]   freq_hundredths
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIVA = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_LOAD = 3'd3;
    localparam logic [2:0] ST_DIVB = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]          state_reg;
    logic [4:0]          cnt_reg;
    logic [EDGE_W-1:0]   div_reg;
    logic [EDGE_W-1:0]   rem_reg;
    logic [RATE_W-1:0]   rate_sh_reg;
    logic [RATE_W-1:0]   q_reg;
    logic [HUND_W-1:0]   lo_reg;
    logic [HUND_W-1:0]   h_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                out_valid_reg;
    logic [EDGE_W-1:0]   out_period_reg;
    logic [FX100_W-1:0]  out_fx_reg;
    logic [RATE_W-1:0]   out_whole_reg;
    logic [HUND_W-1:0]   out_hund_reg;

    logic                shift_bit;
    logic [EDGE_W:0]     trial;
    logic [EDGE_W:0]     trial_sub;
    logic                qbit;
    logic [EDGE_W-1:0]   rem_step;

    assign pop = (state_reg == ST_IDLE) && !q_status.empty && !out_valid_reg;

    assign shift_bit = (state_reg == ST_DIVB) ? lo_reg[HUND_W-1] : rate_sh_reg[RATE_W-1];
    assign trial     = {rem_reg, shift_bit};
    assign trial_sub = trial - {1'b0, div_reg};
    assign qbit      = (trial >= {1'b0, div_reg});
    assign rem_step  = qbit ? trial_sub[EDGE_W-1:0] : trial[EDGE_W-1:0];

    assign out_valid       = out_valid_reg;
    assign period_ticks    = out_period_reg;
    assign freq_x100       = out_fx_reg;
    assign freq_whole_hz   = out_whole_reg;
    assign freq_hundredths = out_hund_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        state_reg <= ST_DIVA;
                    end
                end
                ST_DIVA:
                begin
                    if (cnt_reg == 5'd0)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    state_reg <= ST_DIVB;
                end
                ST_DIVB:
                begin
                    if (cnt_reg == 5'd0)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    state_reg     <= ST_IDLE;
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                div_reg     <= head;
                rate_sh_reg <= count_rate_hz;
                rem_reg     <= '0;
                cnt_reg     <= 5'(RATE_W - 1);
            end
            ST_DIVA:
            begin
                rem_reg     <= rem_step;
                q_reg       <= {q_reg[RATE_W-2:0], qbit};
                rate_sh_reg <= {rate_sh_reg[RATE_W-2:0], 1'b0};
                cnt_reg     <= cnt_reg - 5'd1;
            end
            ST_MUL:
            begin
                prod_reg <= PROD_W'(rem_reg) * PROD_W'(SCALE);
            end
            ST_LOAD:
            begin
                rem_reg <= prod_reg[PROD_W-1:HUND_W];
                lo_reg  <= prod_reg[HUND_W-1:0];
                cnt_reg <= 5'(HUND_W - 1);
            end
            ST_DIVB:
            begin
                rem_reg <= rem_step;
                h_reg   <= {h_reg[HUND_W-2:0], qbit};
                lo_reg  <= {lo_reg[HUND_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 5'd1;
            end
            ST_FIN:
            begin
                out_period_reg <= div_reg;
                out_whole_reg  <= q_reg;
                out_hund_reg   <= h_reg;
                out_fx_reg     <= FX100_W'(q_reg) * FX100_W'(SCALE) + FX100_W'(h_reg);
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

endmodule

/* bench/rfm_checker.sv */
module rfm_checker
    import rfm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [EDGE_W-1:0]     s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [DATA_OUT_W-1:0] m_axis_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    input  logic                  pready,
    output int                    failures,
    output int                    outstanding
);

    typedef struct packed {
        logic [HUND_W-1:0]  hundredths;
        logic [RATE_W-1:0]  whole_hz;
        logic [FX100_W-1:0] freq_x100;
        logic [EDGE_W-1:0]  period;
    } measurement_t;

    logic [RATE_W-1:0] rate_hz;
    logic              awaiting_second;
    logic [EDGE_W-1:0] first_capture;
    measurement_t      pending_meas[$];
    int                fail_count;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch in %s: got %0d, expected %0d", what, got, want);
        fail_count++;
    endtask

    function automatic bit next_measurement(input logic [EDGE_W-1:0] capture,
                                            output measurement_t meas);
        logic [EDGE_W-1:0] ticks;
        logic [63:0]       quotient;
        meas = '0;
        if (!awaiting_second) begin
            first_capture   = capture;
            awaiting_second = 1'b1;
            return 1'b0;
        end
        awaiting_second = 1'b0;
        ticks = capture - first_capture;
        if (ticks == '0) begin
            return 1'b0;
        end
        quotient = (64'(rate_hz) * 64'(SCALE)) / 64'(ticks);
        meas.period     = ticks;
        meas.freq_x100  = FX100_W'(quotient);
        meas.whole_hz   = RATE_W'(quotient / 64'(SCALE));
        meas.hundredths = HUND_W'(quotient % 64'(SCALE));
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        measurement_t got;
        measurement_t want;
        measurement_t fresh;
        if (!rst_n) begin
            rate_hz         = RATE_RESET;
            awaiting_second = 1'b0;
            first_capture   = '0;
            pending_meas.delete();
            fail_count      = 0;
            failures    <= 0;
            outstanding <= 0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = measurement_t'(m_axis_tdata[$bits(measurement_t)-1:0]);
                if (pending_meas.size() == 0) begin
                    report("unexpected result period", 64'(got.period), 64'd0);
                end
                else begin
                    want = pending_meas.pop_front();
                    if (got.period !== want.period)
                        report("period_ticks", 64'(got.period), 64'(want.period));
                    if (got.freq_x100 !== want.freq_x100)
                        report("freq_x100", 64'(got.freq_x100), 64'(want.freq_x100));
                    if (got.whole_hz !== want.whole_hz)
                        report("freq_whole_hz", 64'(got.whole_hz), 64'(want.whole_hz));
                    if (got.hundredths !== want.hundredths)
                        report("freq_hundredths", 64'(got.hundredths), 64'(want.hundredths));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (next_measurement(s_axis_tdata, fresh))
                    pending_meas.push_back(fresh);
            end
            if (psel && penable && pwrite && pready) begin
                if ((paddr >> 2) == REG_COUNT_RATE)
                    rate_hz = RATE_W'(pwdata);
            end
            failures    <= fail_count;
            outstanding <= pending_meas.size();
        end
    end

endmodule

/* bench/reciprocal_frequency_meter_test.sv */
module reciprocal_frequency_meter_test;
    import rfm_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASE_ITEMS = 283;
    localparam int PRESSURE_ITEMS = 30;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam logic [2:0] RATE_ADDR = {REG_COUNT_RATE, 2'b00};
    localparam logic [2:0] UNUSED_ADDR = 3'd4;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [EDGE_W-1:0]     s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [DATA_OUT_W-1:0] m_axis_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int                    failures;
    int                    outstanding;
    int unsigned           cycle_count;
    bit                    no_idle;
    bit                    hold_off_req;
    bit                    second_edge;
    logic [EDGE_W-1:0]     last_first;
    logic [31:0]           phase_rates[6];

    reciprocal_frequency_meter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    rfm_checker meas_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .failures      (failures),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // The receiver stalls in random bursts, and once holds off for a long
    // stretch so that the period queue fills and the edge channel stalls.
    initial
    begin
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (!no_idle && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    task automatic send_edge(input logic [EDGE_W-1:0] capture);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= capture;
        do @(posedge clk); while (!s_axis_tready);
        if (!second_edge)
            last_first = capture;
        second_edge = !second_edge;
    endtask

    task automatic send_pair(input logic [EDGE_W-1:0] first, input logic [EDGE_W-1:0] second);
        send_edge(first);
        send_edge(second);
    endtask

    function automatic logic [EDGE_W-1:0] random_edge();
        logic [EDGE_W-1:0] delta;
        if (!second_edge) begin
            if ($urandom_range(0, 3) == 0)
                return 32'hFFFF_FFFF - $urandom_range(0, 1000);
            return $urandom;
        end
        case ($urandom_range(0, 7))
            0:       delta = '0;
            1, 2, 3: delta = $urandom_range(1, 1000);
            4, 5:    delta = $urandom_range(1, 1000000);
            default: delta = $urandom;
        endcase
        return last_first + delta;
    endfunction

    // Waits until every expected result has arrived, then lets the divider
    // run out before anything else happens.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        no_idle      = 1'b0;
        hold_off_req = 1'b0;
        second_edge  = 1'b0;
        last_first   = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pair(32'd0, 32'd1);
        send_pair(32'hFFFF_FFFF, 32'd0);
        send_pair(32'd7, 32'd7);
        send_pair(32'd0, 32'hFFFF_FFFF);
        send_pair(32'h8000_0000, 32'h7FFF_FFFF);
        send_pair(32'd1000, 32'd1001000);
        settle();
        write_reg(RATE_ADDR, 32'd100000000);
        send_pair(32'd10, 32'd11);
        settle();
        write_reg(RATE_ADDR, 32'hFFFF_FFFF);
        send_pair(32'd0, 32'd1);
        settle();
        write_reg(RATE_ADDR, 32'd0);
        send_pair(32'd5, 32'd12);
        settle();
        write_reg(UNUSED_ADDR, 32'd1000);
        send_pair(32'd0, 32'd2);
        settle();
        write_reg(RATE_ADDR, 32'd1);
        send_pair(32'd0, 32'd1);
        send_pair(32'd0, 32'd300);
        settle();

        write_reg(RATE_ADDR, $urandom_range(1, 100000000));
        no_idle      = 1'b1;
        hold_off_req = 1'b1;
        repeat (PRESSURE_ITEMS) send_edge(random_edge());
        no_idle = 1'b0;

        phase_rates[0] = 32'd1000000;
        phase_rates[1] = 32'd1;
        phase_rates[2] = 32'd100000000;
        phase_rates[3] = $urandom;
        phase_rates[4] = 32'd0;
        phase_rates[5] = $urandom_range(1, 100000000);
        for (int p = 0; p < 6; p++)
        begin
            settle();
            write_reg(RATE_ADDR, phase_rates[p]);
            no_idle = (p == 5);
            repeat (PHASE_ITEMS) send_edge(random_edge());
        end
        settle();

        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
sv/rfm_pkg.sv
sv/rfm_front.sv
sv/rfm_queue.sv
sv/rfm_back.sv
sv/reciprocal_frequency_meter.sv
bench/rfm_checker.sv
bench/reciprocal_frequency_meter_test.sv
